@@ src/bro_pkg.sv @@
// types, codes and constants shared by the bitmap rotator files
package bro_pkg;

    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD   = 2'd0;
    localparam op_t OP_FETCH  = 2'd1;
    localparam op_t OP_REWIND = 2'd2;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_ROWS = 1'b0;
    localparam reg_idx_t REG_COLS = 1'b1;

    localparam logic [8:0] ROWS_RESET = 9'd128;
    localparam logic [8:0] COLS_RESET = 9'd250;
    localparam logic [8:0] SIZE_MAX   = 9'd256;

    typedef struct packed {
        op_t         operation;
        logic [11:0] src_addr;
        logic [7:0]  src_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       overrun;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REWIND,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage

@@ src/bro_if.sv @@
// valid/ready channel interfaces for command and result items
interface bro_in_if;
    import bro_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bro_out_if;
    import bro_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/bro_ram.sv @@
// generic single write port ram with registered read
module bro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/bitmap_rotate_ninety.sv @@
// top level of the 1 bpp bitmap rotator, rotates a stored image by ninety degrees
// A load item writes one source byte when its address lies within the store. A
// fetch item walks up to eight output pixels, one source store read per pixel in
// range through the single read port of the store. With a full byte the fetch
// holds the input through the accepting step, a read step for each of the eight
// pixels and a step to collect the last read into the result register, which
// then drives the result output. A fetch that reaches the final pixel early has
// fewer read steps. A fetch after the image is complete goes straight to the collect step. A result
// held back by the receiver keeps a fetch in its collect step until the output
// register is free. A rewind item, and any write of rows or cols, runs the
// rewind and setup steps, in which the start index (rows-1)*cols is formed by one
// registered multiply; the block also runs this setup right after reset. The
// input is not ready while an item is in work or while a register is written;
// a waiting result does not hold off loads or rewinds.
module bitmap_rotate_ninety #(
    parameter int SOURCE_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  bro_pkg::reg_idx_t  cfg_index,
    input  logic [8:0]         cfg_data,
    bro_in_if.sink             cmd,
    bro_out_if.source          res
);
    import bro_pkg::*;

    localparam int          ADDR_W    = $clog2(SOURCE_BYTES);
    localparam logic [16:0] SRC_LIMIT = 17'(SOURCE_BYTES);

    state_t      state_reg, state_next;
    logic [8:0]  rows_reg, rows_next;
    logic [8:0]  cols_reg, cols_next;
    logic [15:0] prod_reg, prod_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] ctop_reg, ctop_next;
    logic [8:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic        done_reg, done_next;
    logic [2:0]  k_reg, k_next;
    logic [7:0]  acc_reg, acc_next;
    logic        last_reg, last_next;
    logic        over_reg, over_next;
    logic        pv_reg, pv_next;
    logic [2:0]  pk_reg, pk_next;
    logic [2:0]  pb_reg, pb_next;
    logic        ovalid_reg, ovalid_next;
    out_item_t   oitem_reg, oitem_next;

    logic [7:0]  rows_m1;
    logic [16:0] load_addr;
    logic [16:0] byte_addr;
    logic        in_range;
    logic        last_pix;
    logic [8:0]  cfg_clamped;
    logic [7:0]  acc_folded;
    logic [2:0]  acc_pos;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    bro_ram #(
        .WIDTH (8),
        .DEPTH (SOURCE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.data.src_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rows_m1     = (rows_reg == 9'd0) ? 8'd0 : 8'(rows_reg - 9'd1);
    assign load_addr   = {5'd0, cmd.data.src_addr};
    assign byte_addr   = {4'd0, idx_reg[15:3]};
    assign in_range    = byte_addr < SRC_LIMIT;
    assign last_pix    = (row_reg == 8'd0) && (col_reg == cols_reg - 9'd1);
    assign cfg_clamped = (cfg_data > SIZE_MAX) ? SIZE_MAX : cfg_data;
    assign acc_pos     = ~pk_reg;
    assign ram_waddr   = load_addr[ADDR_W-1:0];
    assign ram_raddr   = byte_addr[ADDR_W-1:0];

    assign cmd.ready = (state_reg == ST_IDLE) && !cfg_we;
    assign res.valid = ovalid_reg;
    assign res.data  = oitem_reg;

    always_comb
    begin
        acc_folded = acc_reg;
        if (pv_reg)
        begin
            acc_folded[acc_pos] = ram_rdata[pb_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_REWIND;
            rows_reg   <= ROWS_RESET;
            cols_reg   <= COLS_RESET;
            done_reg   <= 1'b0;
            k_reg      <= 3'd0;
            pv_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            done_reg   <= done_next;
            k_reg      <= k_next;
            pv_reg     <= pv_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        idx_reg   <= idx_next;
        ctop_reg  <= ctop_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        acc_reg   <= acc_next;
        last_reg  <= last_next;
        over_reg  <= over_next;
        pk_reg    <= pk_next;
        pb_reg    <= pb_next;
        oitem_reg <= oitem_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        prod_next   = prod_reg;
        idx_next    = idx_reg;
        ctop_next   = ctop_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        done_next   = done_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        last_next   = last_reg;
        over_next   = over_reg;
        pv_next     = pv_reg;
        pk_next     = pk_reg;
        pb_next     = pb_reg;
        ovalid_next = ovalid_reg;
        oitem_next  = oitem_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (res.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid && !cfg_we)
                begin
                    case (cmd.data.operation)
                        OP_LOAD:
                        begin
                            ram_we = load_addr < SRC_LIMIT;
                        end
                        OP_FETCH:
                        begin
                            pv_next = 1'b0;
                            k_next  = 3'd0;
                            if (done_reg)
                            begin
                                acc_next   = 8'd0;
                                last_next  = 1'b0;
                                over_next  = 1'b1;
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                acc_next   = 8'd0;
                                last_next  = 1'b0;
                                over_next  = 1'b0;
                                state_next = ST_RUN;
                            end
                        end
                        OP_REWIND:
                        begin
                            state_next = ST_REWIND;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_REWIND:
            begin
                prod_next  = {8'd0, rows_m1} * {7'd0, cols_reg};
                state_next = ST_SETUP;
            end

            ST_SETUP:
            begin
                idx_next   = prod_reg;
                ctop_next  = prod_reg;
                col_next   = 9'd0;
                row_next   = rows_m1;
                done_next  = (rows_reg == 9'd0) || (cols_reg == 9'd0);
                state_next = ST_IDLE;
            end

            ST_RUN:
            begin
                // collect the bit read last cycle, issue the read for this pixel
                acc_next = acc_folded;
                ram_re   = in_range;
                pv_next  = in_range;
                pk_next  = k_reg;
                pb_next  = ~idx_reg[2:0];
                if (!in_range)
                begin
                    over_next = 1'b1;
                end
                if (row_reg == 8'd0)
                begin
                    // next source column, starting again at the bottom row
                    row_next  = rows_m1;
                    col_next  = col_reg + 9'd1;
                    ctop_next = ctop_reg + 16'd1;
                    idx_next  = ctop_reg + 16'd1;
                end
                else
                begin
                    row_next = row_reg - 8'd1;
                    idx_next = idx_reg - 16'(cols_reg);
                end
                k_next = k_reg + 3'd1;
                if (last_pix)
                begin
                    done_next  = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_DRAIN;
                end
                else if (k_reg == 3'd7)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    oitem_next.out_byte  = acc_folded;
                    oitem_next.last_byte = last_reg;
                    oitem_next.overrun   = over_reg;
                    ovalid_next          = 1'b1;
                    pv_next              = 1'b0;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a size write restarts the output setup from any step
        if (cfg_we)
        begin
            if (cfg_index == REG_ROWS)
            begin
                rows_next = cfg_clamped;
            end
            else
            begin
                cols_next = cfg_clamped;
            end
            pv_next    = 1'b0;
            state_next = ST_REWIND;
        end
    end

`ifndef SYNTHESIS
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("result appeared outside the drain step");

    a_done_fetch_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cmd.valid && !cfg_we && done_reg
            && cmd.data.operation == OP_FETCH) |=> (state_reg == ST_DRAIN))
        else $error("fetch after completion did not go straight to the result");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_RUN) |-> (row_reg <= rows_m1))
        else $error("row cursor beyond the image");

    a_pending_read: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("store read pending outside a fetch");
`endif

endmodule
